[src/fqs_pkg.sv]
package fqs_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // operation codes
  localparam logic [2:0] OP_ENQ   = 3'd0;
  localparam logic [2:0] OP_DEQ   = 3'd1;
  localparam logic [2:0] OP_PEEK  = 3'd2;
  localparam logic [2:0] OP_FIND  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [31:0] RD_EMPTY = '1;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               found;
    logic               is_empty;
    logic [1:0]         status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic commit;
    logic scan_step;
    logic load_res;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_search;
    logic empty;
    logic hit;
    logic last;
  } stat_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(DEPTH - 1)) r = '0;
    else                        r = i + 1'b1;
    return r;
  endfunction

endpackage

[src/fqs_ctrl.sv]
module fqs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  fqs_pkg::stat_t stat_i,
  output fqs_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.is_search && !stat_i.empty) begin
          state_d = S_SCAN;
        end else if (out_free) begin
          cmd_o.commit   = 1'b1;
          cmd_o.load_res = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat_i.hit || stat_i.last) begin
          if (out_free) begin
            cmd_o.load_res = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_res || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.load_res)
    else $error("result loaded while previous one still stalled");

  // input is taken only while no item is in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch |=> (state_q == S_EXEC))
    else $error("accepted item did not enter execution");

  // a scan only starts for a search
  a_scan_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> stat_i.is_search)
    else $error("scan running for a non-search operation");

endmodule

[src/fqs_datapath.sv]
module fqs_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fqs_pkg::in_item_t  in_data_i,
  input  fqs_pkg::cmd_t      cmd_i,
  output fqs_pkg::stat_t     stat_o,
  output fqs_pkg::out_item_t out_data_o
);

  localparam int Dw = fqs_pkg::DATA_WIDTH;
  localparam int Iw = fqs_pkg::IDX_W;
  localparam int Cw = fqs_pkg::CNT_W;

  logic [Dw-1:0] mem [fqs_pkg::DEPTH];

  logic [Iw-1:0] head_q, head_d, tail_q, tail_d;
  logic [Cw-1:0] count_q, count_d;
  logic [2:0]    op_q;
  logic [Dw-1:0] value_q;
  logic [Dw-1:0] rdata_q;
  logic [Iw-1:0] scan_idx_q;
  logic [Iw-1:0] scan_n_q;
  logic [Iw-1:0] rd_addr;
  logic          full, empty, wr_en;
  fqs_pkg::out_item_t res, out_q;

  assign full  = (count_q == Cw'(fqs_pkg::DEPTH));
  assign empty = (count_q == '0);
  assign wr_en = cmd_i.commit && (op_q == fqs_pkg::OP_ENQ) && !full;

  assign stat_o.is_search = (op_q == fqs_pkg::OP_FIND);
  assign stat_o.empty     = empty;
  assign stat_o.hit       = (rdata_q == value_q);
  assign stat_o.last      = ({1'b0, scan_n_q} == Cw'(count_q - 1'b1));

  assign rd_addr = cmd_i.scan_step ? fqs_pkg::next_idx(scan_idx_q) : head_q;

  // pointer and count update
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.commit) begin
      case (op_q) inside
        fqs_pkg::OP_ENQ: begin
          if (!full) begin
            tail_d  = fqs_pkg::next_idx(tail_q);
            count_d = count_q + 1'b1;
          end
        end
        fqs_pkg::OP_DEQ: begin
          if (!empty) begin
            head_d  = fqs_pkg::next_idx(head_q);
            count_d = count_q - 1'b1;
          end
        end
        fqs_pkg::OP_CLEAR: begin
          head_d  = '0;
          tail_d  = '0;
          count_d = '0;
        end
        default: ;
      endcase
    end
  end

  // result fields
  always_comb begin
    res          = '0;
    res.is_empty = (count_d == '0);
    res.status   = fqs_pkg::ST_OK;
    unique case (op_q) inside
      fqs_pkg::OP_ENQ: begin
        if (full) res.status = fqs_pkg::ST_FULL;
      end
      fqs_pkg::OP_DEQ, fqs_pkg::OP_PEEK: begin
        if (empty) begin
          res.read_value = fqs_pkg::RD_EMPTY;
          res.status     = fqs_pkg::ST_EMPTY;
        end else begin
          res.read_value = 32'(signed'(rdata_q));
        end
      end
      fqs_pkg::OP_FIND: res.found = !empty && stat_o.hit;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= in_data_i.func;
      value_q <= Dw'(in_data_i.value);
    end
    if (cmd_i.latch) begin
      scan_idx_q <= head_q;
      scan_n_q   <= '0;
    end else if (cmd_i.scan_step) begin
      scan_idx_q <= fqs_pkg::next_idx(scan_idx_q);
      scan_n_q   <= scan_n_q + 1'b1;
    end
    if (cmd_i.load_res) out_q <= res;
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[tail_q] <= value_q;
    if (cmd_i.latch || cmd_i.scan_step) rdata_q <= mem[rd_addr];
  end

  assign out_data_o = out_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Cw'(fqs_pkg::DEPTH))
    else $error("entry count above depth");

  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty || full) |-> (head_q == tail_q))
    else $error("head and tail disagree with empty or full count");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> ({1'b0, scan_n_q} < count_q))
    else $error("scan stepped past stored entries");

endmodule

[src/fifo_queue_with_search.sv]
// fifo queue with search: a ring of fqs_pkg::DEPTH signed words taking one
// request at a time (enqueue, dequeue, peek, search, clear) and giving one
// result per request with the empty flag after the operation and a status
// (ok, was empty, full and dropped). enqueue, dequeue, peek, clear, unknown
// codes and a search of an empty queue load their result from the execute
// state once the output is free; a search of a filled queue moves to the
// scan state, compares up to the number of stored entries one entry per
// cycle through the single registered read port of the entry memory, and
// loads its result once an entry matches or the last one is compared and
// the output is free. the next transaction is accepted in the cycle after a
// result is loaded, even while that result is still stalled at the output
module fifo_queue_with_search (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fqs_pkg::in_item_t  in_data_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fqs_pkg::out_item_t out_data_o
);

  // command and status between controller and datapath
  fqs_pkg::cmd_t  cmd;
  fqs_pkg::stat_t stat;

  // sequencer: accept, execute, scan, result handoff
  fqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // ring storage, pointers, compare and result register
  fqs_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule
